[rtl/core/fde_pkg.sv]
// ----------------------------------------------------------------------------
// fde_pkg
// shared constants, register indexes and helpers of the feedback delay echo
// ----------------------------------------------------------------------------
package fde_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int MAX_DELAY    = 65536;

	localparam int CH_W     = $clog2(MAX_CHANNELS);
	localparam int CNT_W    = 4;
	localparam int POS_W    = $clog2(MAX_DELAY);
	localparam int ADDR_W   = CH_W + POS_W;
	localparam int DEPTH    = MAX_CHANNELS * MAX_DELAY;
	localparam int SAMPLE_W = 16;
	localparam int FB_W     = 8;
	localparam int MIX_W    = 9;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;
	localparam int SUM_W    = 27;

	localparam logic [FB_W-1:0]  FB_MAX   = FB_W'(243);
	localparam logic [MIX_W-1:0] MIX_FULL = MIX_W'(256);

	typedef enum logic [IDX_W-1:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_DELAY_LENGTH  = 3'd1,
		REG_FEEDBACK_GAIN = 3'd2,
		REG_WET_MIX       = 3'd3,
		REG_ECHO_ENABLE   = 3'd4
	} reg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	function automatic sample_t sat16(input logic signed [SUM_W-1:0] v);
		sample_t r;
		if (v > SUM_W'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -SUM_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/feedback_delay_echo.sv]
// ----------------------------------------------------------------------------
// feedback_delay_echo
// multichannel feedback echo with integer delay and dry/wet blend
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while sample_stall is low. Its result
// goes from stage 1 into the output register and is held there, so one more
// sample is still taken into stage 1 while that result waits. The throughput
// is set by the feedback loop: the delayed word (memory read data or a
// forwarded pending write) goes through one multiply, add and saturate
// combinationally into the write register. After reset all 524288 memory
// words are cleared one word per cycle, with sample_stall held high;
// configuration writes are taken during that time. Configuration must be
// written only while no sample is in flight; the block does not enforce this.
module feedback_delay_echo
	import fde_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic signed [15:0]  sample_in,
	input  logic [CH_W-1:0]     channel_index,
	input  logic                frame_end,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [15:0]  sample_out,
	output logic [CH_W-1:0]     channel_out
);

	logic [CNT_W-1:0] chan_cnt_q;
	logic [POS_W-1:0] delay_q;
	logic [FB_W-1:0]  fb_q;
	logic [MIX_W-1:0] mix_q;
	logic             enable_q;
	logic [POS_W-1:0] wpos_q;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              in_go;
	logic              s1_go;
	logic [CNT_W-1:0]  chans_eff;
	logic [POS_W-1:0]  delay_eff;
	logic [FB_W-1:0]   fb_eff;
	logic [MIX_W-1:0]  mix_eff;
	logic              active;
	logic [ADDR_W-1:0] raddr;

	logic              valid_s1;
	logic              first_s1;
	logic              act_s1;
	sample_t           x_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [MIX_W-1:0]  mix_s1;
	logic [ADDR_W-1:0] raddr_s1;
	logic [ADDR_W-1:0] waddr_s1;
	sample_t           dly_q;

	logic              wr_v_s2;
	logic [ADDR_W-1:0] wr_a_s2;
	sample_t           wr_d_s2;
	logic              wr_v_s3;
	logic [ADDR_W-1:0] wr_a_s3;
	sample_t           wr_d_s3;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	sample_t           ram_wd;
	logic [15:0]       ram_rd;

	sample_t                  fwd;
	sample_t                  dly;
	logic signed [24:0]       fb_prod;
	logic signed [17:0]       fb_sum;
	sample_t                  wval;
	logic signed [25:0]       px;
	logic signed [25:0]       pd;

	logic signed [25:0]       px_q;
	logic signed [25:0]       pd_q;
	logic [CH_W-1:0]          ch_q;
	logic signed [SUM_W-1:0]  blend;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= CNT_W'(2);
			delay_q    <= POS_W'(1);
			fb_q       <= '0;
			mix_q      <= '0;
			enable_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[CNT_W-1:0];
				REG_DELAY_LENGTH:  delay_q    <= cfg_data[POS_W-1:0];
				REG_FEEDBACK_GAIN: fb_q       <= cfg_data[FB_W-1:0];
				REG_WET_MIX:       mix_q      <= cfg_data[MIX_W-1:0];
				REG_ECHO_ENABLE:   enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective settings
	always_comb begin
		chans_eff = chan_cnt_q;
		if (chan_cnt_q == '0) begin
			chans_eff = CNT_W'(1);
		end else if (chan_cnt_q > CNT_W'(MAX_CHANNELS)) begin
			chans_eff = CNT_W'(MAX_CHANNELS);
		end
		delay_eff = (delay_q == '0) ? POS_W'(1) : delay_q;
		fb_eff    = (fb_q > FB_MAX) ? FB_MAX : fb_q;
		active    = CNT_W'(channel_index) < chans_eff;
		mix_eff   = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
		if (!enable_q || !active) begin
			mix_eff = '0;
		end
		raddr = {channel_index, wpos_q - delay_eff};
	end

	assign s1_go        = !result_valid || !result_stall;
	assign sample_stall = clr_busy_q || (valid_s1 && !s1_go);
	assign in_go        = sample_valid && !sample_stall;

	// memory clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
		end else if (in_go && frame_end) begin
			wpos_q <= wpos_q + POS_W'(1);
		end
	end

	assign ram_we = clr_busy_q || wr_v_s2;
	assign ram_wa = clr_busy_q ? clr_addr_q : wr_a_s2;
	assign ram_wd = clr_busy_q ? '0 : wr_d_s2;

	fde_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.re   (in_go && active),
		.raddr(raddr),
		.rdata(ram_rd)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			first_s1 <= in_go;
			if (in_go) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			act_s1   <= active;
			x_s1     <= sample_in;
			ch_s1    <= channel_index;
			mix_s1   <= mix_eff;
			raddr_s1 <= raddr;
			waddr_s1 <= {channel_index, wpos_q};
		end
		dly_q <= dly;
	end

	// forwarding of writes not yet seen by the read, then the feedback loop
	always_comb begin
		if (wr_v_s2 && wr_a_s2 == raddr_s1) begin
			fwd = wr_d_s2;
		end else if (wr_v_s3 && wr_a_s3 == raddr_s1) begin
			fwd = wr_d_s3;
		end else begin
			fwd = ram_rd;
		end
		dly = first_s1 ? fwd : dly_q;
		// inactive channel never reads the store
		if (!act_s1) begin
			dly = '0;
		end
		fb_prod = dly * $signed({1'b0, fb_eff});
		fb_sum  = 18'(x_s1) + 18'(fb_prod >>> 8);
		wval    = sat16(SUM_W'(fb_sum));
		px      = x_s1 * $signed({1'b0, MIX_FULL - mix_s1});
		pd      = dly * $signed({1'b0, mix_s1});
	end

	// pending writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s2 <= 1'b0;
			wr_v_s3 <= 1'b0;
		end else begin
			wr_v_s2 <= valid_s1 && s1_go && act_s1;
			wr_v_s3 <= wr_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		wr_a_s2 <= waddr_s1;
		wr_d_s2 <= wval;
		wr_a_s3 <= wr_a_s2;
		wr_d_s3 <= wr_d_s2;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_go) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && valid_s1) begin
			px_q <= px;
			pd_q <= pd;
			ch_q <= ch_s1;
		end
	end

	assign blend       = (SUM_W'(px_q) + SUM_W'(pd_q)) >>> 8;
	assign sample_out  = sat16(blend);
	assign channel_out = ch_q;

`ifndef SYNTHESIS
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr_v_s2)
		else $error("item write during memory clear");

	a_first_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		first_s1 |-> valid_s1)
		else $error("stage 1 first cycle without an item");

	a_write_from_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s2 |-> $past(valid_s1) && $past(act_s1))
		else $error("write without an active stage 1 item");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && !first_s1)
		else $error("held stage 1 item lost");
`endif

endmodule

[rtl/core/fde_ram.sv]
// ----------------------------------------------------------------------------
// fde_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module fde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[tb/sv/tb_feedback_delay_echo.sv]
// ----------------------------------------------------------------------------
// tb_feedback_delay_echo
// self-checking bench for the multichannel feedback echo
// ----------------------------------------------------------------------------
// A local model of the echo store, the write position and the registers
// predicts each output sample and channel at the input transfer. Output
// transfers are compared in order against the predicted queue. The run
// covers reset defaults, register extremes and clamping, inactive
// channels, frame sequences under random idling, a long output hold-off
// that fills the block, and back-to-back frames at the longest delay.
// ----------------------------------------------------------------------------
module tb_feedback_delay_echo;
	import fde_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		sample_t         sample;
		logic [CH_W-1:0] chan;
	} echo_result_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_write     = 1'b0;
	logic [IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_W-1:0]  cfg_data      = '0;
	logic              sample_valid  = 1'b0;
	logic              sample_stall;
	sample_t           sample_in     = '0;
	logic [CH_W-1:0]   channel_index = '0;
	logic              frame_end     = 1'b0;
	logic              result_valid;
	logic              result_stall  = 1'b0;
	sample_t           sample_out;
	logic [CH_W-1:0]   channel_out;

	// local copy of the block state
	sample_t           echo_mem [DEPTH];
	logic [POS_W-1:0]  write_pos;
	logic [CNT_W-1:0]  reg_channels;
	logic [15:0]       reg_delay;
	logic [FB_W-1:0]   reg_feedback;
	logic [MIX_W-1:0]  reg_mix;
	logic              reg_enable;

	echo_result_t      pending_outputs [$];
	echo_result_t      want;
	int                errors      = 0;
	int                cycle_count = 0;
	int                burst_left  = 0;
	bit                tx_steady   = 1'b0;
	bit                rx_free     = 1'b0;
	int                hold_requests = 0;
	int                hold_seen     = 0;
	int                hold_left     = 0;
	int                mode_left     = 0;
	int                stall_mode    = 0;

	feedback_delay_echo i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_in     (sample_in),
		.channel_index (channel_index),
		.frame_end     (frame_end),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sample_out    (sample_out),
		.channel_out   (channel_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic sample_t clip16(input int v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return sample_t'(v);
	endfunction

	function automatic int active_channels();
		if (reg_channels == 0) begin
			return 1;
		end else if (reg_channels > MAX_CHANNELS) begin
			return MAX_CHANNELS;
		end
		return int'(reg_channels);
	endfunction

	// advances the local state by one input sample and returns the output sample
	function automatic sample_t echo_predict(input sample_t x, input logic [CH_W-1:0] ch,
			input logic fe);
		logic [POS_W-1:0] dly;
		logic [POS_W-1:0] rd;
		int               xi;
		int               di;
		int               fb;
		int               mix;
		sample_t          y;
		xi = x;
		y  = x;
		if (int'(ch) < active_channels()) begin
			dly = (reg_delay == 0) ? POS_W'(1) : reg_delay;
			fb  = (reg_feedback > FB_MAX) ? int'(FB_MAX) : int'(reg_feedback);
			mix = (reg_mix > MIX_FULL) ? int'(MIX_FULL) : int'(reg_mix);
			if (!reg_enable) begin
				mix = 0;
			end
			rd = write_pos - dly;
			di = echo_mem[{ch, rd}];
			echo_mem[{ch, write_pos}] = clip16(xi + ((di * fb) >>> 8));
			y = clip16((xi * (256 - mix) + di * mix) >>> 8);
		end
		if (fe) begin
			write_pos = write_pos + 1'b1;
		end
		return y;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		logic [CFG_W-1:0] data;
		data = CFG_W'(value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (reg_idx_t'(idx))
			REG_CHANNEL_COUNT: reg_channels = data[CNT_W-1:0];
			REG_DELAY_LENGTH:  reg_delay    = data[15:0];
			REG_FEEDBACK_GAIN: reg_feedback = data[FB_W-1:0];
			REG_WET_MIX:       reg_mix      = data[MIX_W-1:0];
			REG_ECHO_ENABLE:   reg_enable   = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_echo(input int chans, input int dly, input int fb, input int mix,
			input int en);
		write_reg(REG_CHANNEL_COUNT, chans);
		write_reg(REG_DELAY_LENGTH, dly);
		write_reg(REG_FEEDBACK_GAIN, fb);
		write_reg(REG_WET_MIX, mix);
		write_reg(REG_ECHO_ENABLE, en);
	endtask

	// one input transfer, with bursts and gaps unless steady
	task automatic send_sample(input sample_t x, input logic [CH_W-1:0] ch, input logic fe);
		int  gap;
		bit  taken;
		echo_result_t r;
		if (!tx_steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		sample_valid  <= 1'b1;
		sample_in     <= x;
		channel_index <= ch;
		frame_end     <= fe;
		do begin
			@(negedge clk);
			taken = !sample_stall;
			@(posedge clk);
		end while (!taken);
		r.sample = echo_predict(x, ch, fe);
		r.chan   = ch;
		pending_outputs.push_back(r);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// output side stall pattern and long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (rx_free) begin
			result_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left  = $urandom_range(10, 80);
				stall_mode = $urandom_range(0, 2);
			end
			mode_left--;
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= ($urandom_range(0, 4) > 1);
			endcase
		end
	end

	// output transfer check
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected output transfer: sample_out=%0d channel_out=%0d",
					sample_out, channel_out);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample, sample_out);
					errors++;
				end
				if (channel_out !== want.chan) begin
					$error("channel_out: expected %0d, got %0d", want.chan, channel_out);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_defaults();
		send_sample(16'sh7fff, 3'd0, 1'b0);
		send_sample(16'sh8000, 3'd1, 1'b1);
		send_sample(16'sh0000, 3'd0, 1'b0);
		send_sample(-16'sd1,   3'd1, 1'b1);
		send_sample(16'sd12345, 3'd2, 1'b1);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		int i;
		// zero channel count, zero delay, feedback and mix over their caps
		set_echo(0, 0, 255, 511, 1);
		for (i = 0; i < 3; i++) send_sample(16'sh7fff, 3'd0, 1'b1);
		for (i = 0; i < 3; i++) send_sample(16'sh8000, 3'd0, 1'b1);
		send_sample(16'sd100, 3'd1, 1'b0);
		wait_idle();
		// spare indexes must not disturb anything
		set_echo(15, 65535, 0, 511, 0);
		write_reg(REG_SPARE_LO, 16'hffff);
		write_reg(REG_SPARE_HI, 16'hffff);
		send_sample(16'sh8000, 3'd7, 1'b0);
		send_sample(16'sh7fff, 3'd7, 1'b1);
		send_sample(-16'sd1, 3'd3, 1'b1);
		wait_idle();
		set_echo(8, 2, 243, 256, 1);
		for (i = 0; i < 4; i++) send_sample(rand_sample(), CH_W'(i), 1'b0);
		send_sample(rand_sample(), 3'd7, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int phase;
		int items;
		int n;
		int c;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_echo(8, 1, 243, 256, 1);
				1: set_echo(0, 0, 255, 511, 1);
				2: set_echo(15, 65535, 0, 0, 0);
				default: set_echo($urandom_range(0, 15),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 6),
					$urandom_range(0, 255), $urandom_range(0, 511),
					($urandom_range(0, 3) != 0));
			endcase
			items = 0;
			while (items < 60) begin
				if ($urandom_range(0, 9) < 8) begin
					n = active_channels();
					for (c = 0; c < n; c++) begin
						send_sample(rand_sample(), CH_W'(c), c == n - 1);
						items++;
					end
				end else begin
					send_sample(rand_sample(), CH_W'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)));
					items++;
				end
			end
			wait_idle();
		end
	endtask

	task automatic test_output_hold();
		int i;
		set_echo(4, 2, 200, 128, 1);
		tx_steady = 1'b1;
		hold_requests++;
		for (i = 0; i < 60; i++) send_sample(rand_sample(), CH_W'(i % 4), (i % 4) == 3);
		tx_steady = 1'b0;
		wait_idle();
	endtask

	task automatic test_longest_delay();
		int i;
		set_echo(1, 65535, 128, 256, 1);
		tx_steady = 1'b1;
		rx_free   = 1'b1;
		for (i = 0; i < 40; i++) send_sample(rand_sample(), 3'd0, 1'b1);
		tx_steady = 1'b0;
		rx_free   = 1'b0;
		wait_idle();
	endtask

	initial begin
		foreach (echo_mem[i]) echo_mem[i] = '0;
		write_pos    = '0;
		reg_channels = CNT_W'(2);
		reg_delay    = 16'd1;
		reg_feedback = '0;
		reg_mix      = '0;
		reg_enable   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_frames();
		test_output_hold();
		test_longest_delay();
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/fde_pkg.sv
rtl/core/fde_ram.sv
rtl/core/feedback_delay_echo.sv
tb/sv/tb_feedback_delay_echo.sv
